// ===== hdl/encoder_knob_key_qualifier_defines.svh =====
// Assertion macros shared by the encoder knob key qualifier RTL.
`ifndef ENCODER_KNOB_KEY_QUALIFIER_DEFINES_SVH
`define ENCODER_KNOB_KEY_QUALIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EKQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EKQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/eknq_pkg.sv =====
// Package: widths, register indexes, event codes and helpers for the knob qualifier.
`default_nettype none

package eknq_pkg;

  localparam int COUNT_BITS = 10;
  localparam int REG_W      = 10;
  localparam int IDX_W      = 3;
  localparam int EV_W       = 3;
  localparam int CMP_W      = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SHORT_MIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_MIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_LONG_MAX      = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_WINDOW  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ACTIVITY_HOLD = 3'd4;

  localparam logic [REG_W-1:0] SHORT_MIN_RST     = 10'd10;
  localparam logic [REG_W-1:0] LONG_MIN_RST      = 10'd150;
  localparam logic [REG_W-1:0] LONG_MAX_RST      = 10'd300;
  localparam logic [REG_W-1:0] SPEED_WINDOW_RST  = 10'd100;
  localparam logic [REG_W-1:0] ACTIVITY_HOLD_RST = 10'd200;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
  localparam logic [EV_W-1:0] EV_UP    = 3'd1;
  localparam logic [EV_W-1:0] EV_DOWN  = 3'd2;
  localparam logic [EV_W-1:0] EV_SHORT = 3'd3;
  localparam logic [EV_W-1:0] EV_LONG  = 3'd4;

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [REG_W-1:0]      reg_t;
  typedef logic [EV_W-1:0]       event_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  function automatic count_t sat_inc(input count_t v);
    count_t res;
    res = (v == CNT_MAX) ? v : COUNT_BITS'(v + 1'b1);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/eknq_if.sv =====
// Valid/ready channel interfaces for knob qualifier items and results.
`default_nettype none

interface eknq_in_if;
  logic valid;
  logic ready;
  logic command;
  logic phase_b;
  logic key_pressed;

  modport source (output valid, output command, output phase_b, output key_pressed,
                  input ready);
  modport sink   (input valid, input command, input phase_b, input key_pressed,
                  output ready);
endinterface

interface eknq_out_if;
  logic                    valid;
  logic                    ready;
  logic [eknq_pkg::EV_W-1:0]  event_res;
  logic [eknq_pkg::REG_W-1:0] speed;
  logic                    knob_active;

  modport source (output valid, output event_res, output speed, output knob_active,
                  input ready);
  modport sink   (input valid, input event_res, input speed, input knob_active,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/encoder_knob_key_qualifier.sv =====
// Rotary encoder channel with push key: step, short/long press, speed and activity.
`default_nettype none
`include "encoder_knob_key_qualifier_defines.svh"

// One encoder channel per instance. Every accepted item (a 10 ms tick with the
// key level, or a phase A rising edge with the B level) produces exactly one
// result, registered in the cycle after acceptance. The block takes one item per
// cycle; the only limit is the result register: while a result waits and
// out_ch.ready is low, in_ch.ready drops, otherwise a new item is taken in the
// same cycle the held result leaves. Configuration writes (cfg_we, cfg_index,
// cfg_data) act at the next clock and must be issued while no item is in flight.
module encoder_knob_key_qualifier (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  eknq_in_if.sink                         in_ch,
  eknq_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [eknq_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [eknq_pkg::REG_W-1:0] cfg_data
);
  import eknq_pkg::*;

  // configuration
  reg_t short_min_r, long_min_r, long_max_r, speed_window_r, activity_hold_r;

  // channel state
  count_t press_ticks_r, press_ticks_nxt;
  logic   press_seen_r, press_seen_nxt;
  logic   long_latched_r, long_latched_nxt;
  count_t window_ticks_r, window_ticks_nxt;
  count_t edge_count_r, edge_count_nxt;
  count_t speed_value_r, speed_value_nxt;
  reg_t   activity_left_r, activity_left_nxt;

  // result register
  logic   out_valid_r;
  event_t event_r, event_nxt;
  reg_t   speed_r;
  logic   active_r;

  logic   in_fire;
  count_t pt_inc;
  count_t wt_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r     <= SHORT_MIN_RST;
      long_min_r      <= LONG_MIN_RST;
      long_max_r      <= LONG_MAX_RST;
      speed_window_r  <= SPEED_WINDOW_RST;
      activity_hold_r <= ACTIVITY_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_MIN:     short_min_r     <= cfg_data;
        REG_LONG_MIN:      long_min_r      <= cfg_data;
        REG_LONG_MAX:      long_max_r      <= cfg_data;
        REG_SPEED_WINDOW:  speed_window_r  <= cfg_data;
        REG_ACTIVITY_HOLD: activity_hold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pt_inc = sat_inc(press_ticks_r);
  assign wt_inc = sat_inc(window_ticks_r);

  always_comb begin
    press_ticks_nxt   = press_ticks_r;
    press_seen_nxt    = press_seen_r;
    long_latched_nxt  = long_latched_r;
    window_ticks_nxt  = window_ticks_r;
    edge_count_nxt    = edge_count_r;
    speed_value_nxt   = speed_value_r;
    activity_left_nxt = activity_left_r;
    event_nxt         = EV_NONE;

    if (in_ch.command == CMD_EDGE) begin
      edge_count_nxt    = sat_inc(edge_count_r);
      activity_left_nxt = activity_hold_r;
      event_nxt         = in_ch.phase_b ? EV_DOWN : EV_UP;
    end else begin
      // key: held count stops once a long press is latched
      if (in_ch.key_pressed && !long_latched_r) begin
        press_ticks_nxt = pt_inc;
        press_seen_nxt  = 1'b1;
      end
      if (press_seen_nxt) begin
        if (!in_ch.key_pressed) begin
          if (cmp_t'(press_ticks_nxt) > cmp_t'(short_min_r) &&
              cmp_t'(press_ticks_nxt) < cmp_t'(long_min_r)) begin
            event_nxt = EV_SHORT;
          end
          press_seen_nxt   = 1'b0;
          long_latched_nxt = 1'b0;
          press_ticks_nxt  = '0;
        end else if (!long_latched_r &&
                     cmp_t'(press_ticks_nxt) > cmp_t'(long_min_r) &&
                     cmp_t'(press_ticks_nxt) < cmp_t'(long_max_r)) begin
          event_nxt        = EV_LONG;
          long_latched_nxt = 1'b1;
        end
      end

      // speed window
      if (cmp_t'(wt_inc) >= cmp_t'(speed_window_r)) begin
        speed_value_nxt  = edge_count_r;
        edge_count_nxt   = '0;
        window_ticks_nxt = '0;
      end else begin
        window_ticks_nxt = wt_inc;
      end

      if (activity_left_r != '0) begin
        activity_left_nxt = activity_left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= '0;
      press_seen_r    <= 1'b0;
      long_latched_r  <= 1'b0;
      window_ticks_r  <= '0;
      edge_count_r    <= '0;
      speed_value_r   <= '0;
      activity_left_r <= '0;
    end else if (in_fire) begin
      press_ticks_r   <= press_ticks_nxt;
      press_seen_r    <= press_seen_nxt;
      long_latched_r  <= long_latched_nxt;
      window_ticks_r  <= window_ticks_nxt;
      edge_count_r    <= edge_count_nxt;
      speed_value_r   <= speed_value_nxt;
      activity_left_r <= activity_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_r  <= event_nxt;
      speed_r  <= REG_W'(speed_value_nxt);
      active_r <= (activity_left_nxt != '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_res   = event_r;
  assign out_ch.speed       = speed_r;
  assign out_ch.knob_active = active_r;

  `EKQ_ASSERT_NEXT(a_result_after_item, in_fire, out_valid_r,
                   "accepted item left no result")
  `EKQ_ASSERT_NEXT(a_edge_gives_step, in_fire && in_ch.command == CMD_EDGE,
                   (event_r == EV_UP || event_r == EV_DOWN) && active_r ==
                   (activity_left_r != '0), "edge item gave no step or wrong activity")
  `EKQ_ASSERT_NOW(a_latch_needs_press, long_latched_r, press_seen_r,
                  "long press latched without a held key")
  `EKQ_ASSERT_NEXT(a_release_clears, in_fire && in_ch.command == CMD_TICK &&
                   !in_ch.key_pressed, press_ticks_r == '0 && !press_seen_r &&
                   !long_latched_r, "key release did not clear press state")

endmodule

`default_nettype wire

// ===== bench/encoder_knob_key_qualifier_tb.sv =====
// Testbench for encoder_knob_key_qualifier: directed and random traffic checked against a knob/key predictor.
module encoder_knob_key_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eknq_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic command;
    logic phase_b;
    logic key_pressed;
  } knob_item_t;

  typedef struct packed {
    event_t event_res;
    reg_t   speed;
    logic   knob_active;
  } knob_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  eknq_in_if  in_ch();
  eknq_out_if out_ch();

  encoder_knob_key_qualifier uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // register copies
  reg_t short_min_cfg, long_min_cfg, long_max_cfg, window_cfg, hold_cfg;
  // knob state
  count_t press_ticks, window_ticks, edge_count;
  reg_t   speed_value, activity_left;
  logic   press_seen, long_latched;

  knob_item_t   pending_items[$];
  knob_result_t expected_results[$];
  knob_item_t   cur_item;

  int  pushed;
  int  fail_count;
  int  cycles;
  int  in_gap, out_stall;
  bit  in_idle_on, out_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("encoder_knob_key_qualifier_tb NOT OK");
      $finish;
    end
  end

  function automatic count_t bump_count(input count_t v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // advances the knob state by one item and returns what the block must report
  function automatic knob_result_t advance_knob(input knob_item_t it);
    knob_result_t r;
    r.event_res = EV_NONE;
    if (it.command == CMD_EDGE) begin
      edge_count    = bump_count(edge_count);
      activity_left = hold_cfg;
      r.event_res   = it.phase_b ? EV_DOWN : EV_UP;
    end else begin
      if (it.key_pressed && !long_latched) begin
        press_ticks = bump_count(press_ticks);
        press_seen  = 1'b1;
      end
      if (press_seen) begin
        if (!it.key_pressed) begin
          if (press_ticks > short_min_cfg && press_ticks < long_min_cfg)
            r.event_res = EV_SHORT;
          press_seen   = 1'b0;
          long_latched = 1'b0;
          press_ticks  = '0;
        end
        if (press_ticks > long_min_cfg && press_ticks < long_max_cfg && !long_latched) begin
          r.event_res  = EV_LONG;
          long_latched = 1'b1;
        end
      end
      window_ticks = bump_count(window_ticks);
      if (window_ticks >= window_cfg) begin
        speed_value  = edge_count;
        edge_count   = '0;
        window_ticks = '0;
      end
      if (activity_left != '0)
        activity_left = activity_left - 1'b1;
    end
    r.speed       = speed_value;
    r.knob_active = (activity_left != '0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(advance_knob(cur_item));
      if (in_ch.valid && !in_ch.ready) begin
        // hold the item until taken
      end else if (in_gap != 0) begin
        in_gap      <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        in_ch.command     <= cur_item.command;
        in_ch.phase_b     <= cur_item.phase_b;
        in_ch.key_pressed <= cur_item.key_pressed;
        in_ch.valid       <= 1'b1;
        in_gap            <= in_idle_on ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    knob_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item pending: event_res %0d", out_ch.event_res);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, out_ch.event_res);
            fail_count++;
          end
          if (out_ch.speed !== want.speed) begin
            $error("speed: expected %0d, got %0d", want.speed, out_ch.speed);
            fail_count++;
          end
          if (out_ch.knob_active !== want.knob_active) begin
            $error("knob_active: expected %0d, got %0d", want.knob_active,
                   out_ch.knob_active);
            fail_count++;
          end
        end
      end
      if (out_stall != 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall    <= (out_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  task automatic push_item(input logic cmd, input logic b, input logic key);
    knob_item_t it;
    it.command     = cmd;
    it.phase_b     = b;
    it.key_pressed = key;
    pending_items.push_back(it);
    pushed++;
  endtask

  // unused fields carry random bits
  task automatic put_tick(input logic key);
    push_item(CMD_TICK, 1'($urandom_range(0, 1)), key);
  endtask

  task automatic put_edge(input logic b);
    push_item(CMD_EDGE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic put_press(input int hold, input bit release_key, input int edge_odds);
    for (int i = 0; i < hold; i++) begin
      if (edge_odds != 0 && $urandom_range(0, edge_odds - 1) == 0)
        put_edge(1'($urandom_range(0, 1)));
      put_tick(1'b1);
    end
    if (release_key)
      put_tick(1'b0);
  endtask

  // press lengths clustered on the window boundaries
  function automatic int pick_hold(input int cap);
    int h;
    case ($urandom_range(0, 7))
      0: h = int'(short_min_cfg);
      1: h = int'(short_min_cfg) + 1;
      2: h = int'(long_min_cfg) - 1;
      3: h = int'(long_min_cfg);
      4: h = int'(long_min_cfg) + 1;
      5: h = int'(long_max_cfg);
      6: h = int'(long_max_cfg) + 1;
      default: h = $urandom_range(0, int'(long_max_cfg) + 3);
    endcase
    if (h < 0) h = 0;
    if (h > cap) h = $urandom_range(0, cap);
    return h;
  endfunction

  task automatic random_traffic(input int n, input int cap);
    int stop;
    int r;
    stop = pushed + n;
    while (pushed < stop) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        // one in ten presses is left open and runs into the next
        put_press(pick_hold(cap), $urandom_range(0, 9) != 0, 8);
      end else if (r < 8) begin
        repeat ($urandom_range(1, 6)) put_edge(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 5))
          push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input reg_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SHORT_MIN:     short_min_cfg = data;
      REG_LONG_MIN:      long_min_cfg  = data;
      REG_LONG_MAX:      long_max_cfg  = data;
      REG_SPEED_WINDOW:  window_cfg    = data;
      REG_ACTIVITY_HOLD: hold_cfg      = data;
      default: ;
    endcase
  endtask

  task automatic write_knob_cfg(input int s_min, input int l_min, input int l_max,
                                input int win, input int hold);
    wait_idle();
    write_reg(REG_SHORT_MIN, reg_t'(s_min));
    write_reg(REG_LONG_MIN, reg_t'(l_min));
    write_reg(REG_LONG_MAX, reg_t'(l_max));
    write_reg(REG_SPEED_WINDOW, reg_t'(win));
    write_reg(REG_ACTIVITY_HOLD, reg_t'(hold));
    write_reg(IDX_W'($urandom_range(REG_SPARE, REG_ACTIVITY_HOLD + 1)),
              reg_t'($urandom_range(0, 1023)));
    @(posedge clk);
    cfg_we      <= 1'b0;
    in_idle_on  <= ($urandom_range(0, 3) != 0);
    out_idle_on <= ($urandom_range(0, 3) != 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_SHORT_MIN;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.phase_b     = 1'b0;
    in_ch.key_pressed = 1'b0;
    out_ch.ready      = 1'b0;
    in_idle_on        = 1'b1;
    out_idle_on       = 1'b1;
    pushed            = 0;
    fail_count        = 0;
    cycles            = 0;
    short_min_cfg     = SHORT_MIN_RST;
    long_min_cfg      = LONG_MIN_RST;
    long_max_cfg      = LONG_MAX_RST;
    window_cfg        = SPEED_WINDOW_RST;
    hold_cfg          = ACTIVITY_HOLD_RST;
    press_ticks       = '0;
    window_ticks      = '0;
    edge_count        = '0;
    speed_value       = '0;
    activity_left     = '0;
    press_seen        = 1'b0;
    long_latched      = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: both step directions, a press too short to click
    put_edge(1'b0);
    put_edge(1'b1);
    put_tick(1'b0);
    put_tick(1'b1);
    put_tick(1'b0);

    // tight windows: a click, then a long press with an edge while held
    write_knob_cfg(1, 4, 7, 3, 2);
    put_press(3, 1, 0);
    put_edge(1'b0);
    put_press(7, 0, 0);
    put_edge(1'b1);
    put_tick(1'b0);
    put_tick(1'b0);
    put_tick(1'b0);

    write_knob_cfg(2, 6, 12, 5, 3);
    random_traffic(100, 20);
    write_knob_cfg(0, 0, 0, 1, 0);
    random_traffic(50, 8);
    write_knob_cfg(0, 1, 3, 1, 1023);
    random_traffic(70, 8);
    // no long window left open
    write_knob_cfg(3, 10, 11, 7, 1);
    random_traffic(70, 20);
    repeat (3) begin
      write_knob_cfg($urandom_range(0, 8), $urandom_range(0, 20), $urandom_range(0, 30),
                     $urandom_range(1, 20), $urandom_range(0, 15));
      random_traffic(50, 40);
    end

    // saturate the edge count, then close the window to publish it
    write_knob_cfg(1023, 1023, 1023, 1023, 1023);
    repeat (1030) put_edge(1'($urandom_range(0, 1)));
    write_knob_cfg(1023, 1023, 1023, 1, 1023);
    put_tick(1'b0);
    put_edge(1'b0);
    put_tick(1'b0);
    random_traffic(30, 8);

    write_knob_cfg(100, 115, 130, 40, 50);
    put_press(108, 1, 10);
    put_press(125, 1, 10);
    random_traffic(40, 20);

    write_knob_cfg($urandom_range(0, 6), $urandom_range(0, 15), $urandom_range(0, 25),
                   $urandom_range(1, 12), $urandom_range(0, 10));
    random_traffic(50, 30);

    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0)
      $display("encoder_knob_key_qualifier_tb OK");
    else
      $display("encoder_knob_key_qualifier_tb NOT OK");
    $finish;
  end

endmodule
